@@ sv/tbg_pkg.sv @@
// shared types, widths and constants for the two-body gravity euler step block
package tbg_pkg;

    localparam int STEPS_PER_UNIT = 60;

    // reciprocal of steps per unit, exact truncating divide for any 32-bit magnitude
    localparam int RECIP_SHIFT = 32 + $clog2(STEPS_PER_UNIT);
    localparam logic [32:0] RECIP = 33'(((64'd1 << RECIP_SHIFT) + 64'(STEPS_PER_UNIT)
                                         - 64'd1) / 64'(STEPS_PER_UNIT));
    localparam int PROD_W = 65;

    localparam int MAG_W  = 33;
    localparam int SQ_W   = 66;
    localparam int SRC_W  = 68;
    localparam int ROOT_W = 34;
    localparam int SREM_W = 36;
    localparam int GM_W   = 64;
    localparam int DEN_W  = 100;
    localparam int NUM_W  = 97;
    localparam int FRAC_W = 16;
    localparam int NUMS_W = NUM_W + FRAC_W;
    localparam int QUO_W  = 33;
    localparam int DSH_W  = DEN_W + QUO_W - 1;
    localparam int MUL_W  = 100;
    localparam int MULB_W = 34;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SVX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SVY   = 3'd5;

    localparam logic [31:0] GRAV_RESET = 32'd65536;
    localparam logic [31:0] MASS_RESET = 32'd6553600;

    localparam logic [5:0] MUL_LAST   = 6'(MULB_W);
    localparam logic [5:0] SQRT_LAST  = 6'(ROOT_W);
    localparam logic [5:0] DIV_LAST   = 6'(QUO_W);
    localparam logic [5:0] SCALE_LAST = 6'd4;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_COINCIDE = 2'd1,
        FAULT_MASS     = 2'd2
    } fault_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_CHECK, ST_SQRT, ST_GM, ST_DEN,
        ST_NX, ST_DIVX, ST_NY, ST_DIVY, ST_SCALE, ST_FINISH
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL_SX, OP_MUL_SY, OP_CHECK, OP_SQRT, OP_MUL_GM,
        OP_MUL_DEN, OP_MUL_NX, OP_DIV_X, OP_MUL_NY, OP_DIV_Y, OP_SCALE, OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] cnt;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic s_zero;
        logic mass_zero;
    } stat_t;

endpackage

@@ sv/tbg_ctrl.sv @@
// sequencer that steps the datapath through one euler step per input beat
module tbg_ctrl
    import tbg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       fire;
    logic [5:0] last_cnt;

    assign fire = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (state_reg)
            ST_SQX, ST_SQY, ST_GM, ST_DEN, ST_NX, ST_NY: last_cnt = MUL_LAST;
            ST_SQRT:                                     last_cnt = SQRT_LAST;
            ST_DIVX, ST_DIVY:                            last_cnt = DIV_LAST;
            ST_SCALE:                                    last_cnt = SCALE_LAST;
            default:                                     last_cnt = 6'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 6'd0;
                if (in_valid)
                begin
                    state_next = ST_SQX;
                end
            end
            ST_CHECK:
            begin
                cnt_next   = 6'd0;
                state_next = (stat.s_zero || stat.mass_zero) ? ST_SCALE : ST_SQRT;
            end
            ST_FINISH:
            begin
                cnt_next = 6'd0;
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                if (cnt_reg == last_cnt)
                begin
                    cnt_next = 6'd0;
                    case (state_reg)
                        ST_SQX:   state_next = ST_SQY;
                        ST_SQY:   state_next = ST_CHECK;
                        ST_SQRT:  state_next = ST_GM;
                        ST_GM:    state_next = ST_DEN;
                        ST_DEN:   state_next = ST_NX;
                        ST_NX:    state_next = ST_DIVX;
                        ST_DIVX:  state_next = ST_NY;
                        ST_NY:    state_next = ST_DIVY;
                        ST_DIVY:  state_next = ST_SCALE;
                        ST_SCALE: state_next = ST_FINISH;
                        default:  state_next = ST_IDLE;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_FINISH && fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        cmd.cnt  = cnt_reg;
        cmd.last = (cnt_reg == last_cnt);
        case (state_reg)
            ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_SQX:    cmd.op = OP_MUL_SX;
            ST_SQY:    cmd.op = OP_MUL_SY;
            ST_CHECK:  cmd.op = OP_CHECK;
            ST_SQRT:   cmd.op = OP_SQRT;
            ST_GM:     cmd.op = OP_MUL_GM;
            ST_DEN:    cmd.op = OP_MUL_DEN;
            ST_NX:     cmd.op = OP_MUL_NX;
            ST_DIVX:   cmd.op = OP_DIV_X;
            ST_NY:     cmd.op = OP_MUL_NY;
            ST_DIVY:   cmd.op = OP_DIV_Y;
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_FINISH: cmd.op = fire ? OP_FINISH : OP_NONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/tbg_datapath.sv @@
// datapath: body state, serial multiplier, square root, divider and integration
module tbg_datapath
    import tbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [31:0]   other_x,
    input  logic signed [31:0]   other_y,
    input  logic [31:0]          other_mass,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic signed [31:0]   accel_x,
    output logic signed [31:0]   accel_y,
    output logic [1:0]           fault
);

    logic [31:0]        g_reg, mass_reg, om_reg;
    logic signed [31:0] own_x_reg, own_y_reg, own_vx_reg, own_vy_reg;
    logic [MAG_W-1:0]   magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic [SQ_W-1:0]    s_reg;
    logic [GM_W-1:0]    gm_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [MUL_W-1:0]   mul_a_reg, acc_reg;
    logic [MULB_W-1:0]  mul_b_reg;
    logic [SRC_W-1:0]   sq_src_reg;
    logic [SREM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [NUMS_W-1:0]  div_rem_reg;
    logic [DSH_W-1:0]   div_d_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic               ovf_reg;
    logic signed [31:0] ax_reg, ay_reg;
    fault_t             fault_reg, fault_out_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               pneg_reg;
    logic signed [31:0] qvx_reg, qvy_reg, qax_reg, qay_reg;
    logic signed [31:0] accel_x_reg, accel_y_reg;

    logic [MAG_W-1:0]   dx_next, dy_next;
    logic               is_mul;
    logic [MUL_W-1:0]   mul_a_next, acc_next;
    logic [MULB_W-1:0]  mul_b_next;
    logic [SREM_W+1:0]  sq_rem_t, sq_trial;
    logic               sq_ge;
    logic [SREM_W-1:0]  sq_rem_next;
    logic [ROOT_W-1:0]  root_next;
    logic [NUMS_W-1:0]  num_shift;
    logic               ovf_next;
    logic [DSH_W-1:0]   div_rem_ext;
    logic               div_ge;
    logic [QUO_W-1:0]   quo_next, lim, mag_sel;
    logic               div_neg;
    logic signed [31:0] accel_next;
    logic signed [31:0] sc_val;
    logic [31:0]        sc_mag;
    logic [31:0]        sc_q;
    logic signed [31:0] sc_res;
    logic [1:0]         sc_idx;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] sum;
        sum = {a[31], a} + {b[31], b};
        if (sum[32] != sum[31])
        begin
            sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            sat_add = sum[31:0];
        end
    endfunction

    assign stat.s_zero    = (s_reg == '0);
    assign stat.mass_zero = (mass_reg == '0);

    // displacement to the other body, magnitude kept in 33 bits
    always_comb
    begin
        dx_next = {other_x[31], other_x} - {own_x_reg[31], own_x_reg};
        dy_next = {other_y[31], other_y} - {own_y_reg[31], own_y_reg};
    end

    // serial shift-add multiplier operand select
    always_comb
    begin
        is_mul     = 1'b1;
        mul_a_next = '0;
        mul_b_next = '0;
        case (cmd.op)
            OP_MUL_SX:
            begin
                mul_a_next = MUL_W'(magx_reg);
                mul_b_next = MULB_W'(magx_reg);
            end
            OP_MUL_SY:
            begin
                mul_a_next = MUL_W'(magy_reg);
                mul_b_next = MULB_W'(magy_reg);
            end
            OP_MUL_GM:
            begin
                mul_a_next = MUL_W'(g_reg);
                mul_b_next = MULB_W'(om_reg);
            end
            OP_MUL_DEN:
            begin
                mul_a_next = MUL_W'(s_reg);
                mul_b_next = root_reg;
            end
            OP_MUL_NX:
            begin
                mul_a_next = MUL_W'(gm_reg);
                mul_b_next = MULB_W'(magx_reg);
            end
            OP_MUL_NY:
            begin
                mul_a_next = MUL_W'(gm_reg);
                mul_b_next = MULB_W'(magy_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        acc_next = acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);
    end

    // two bits of the radicand per step
    always_comb
    begin
        sq_rem_t    = {sq_rem_reg, sq_src_reg[SRC_W-1 -: 2]};
        sq_trial    = (SREM_W+2)'({root_reg, 2'b01});
        sq_ge       = (sq_rem_t >= sq_trial);
        sq_rem_next = sq_ge ? SREM_W'(sq_rem_t - sq_trial) : SREM_W'(sq_rem_t);
        root_next   = {root_reg[ROOT_W-2:0], sq_ge};
    end

    // restoring divider, one quotient bit per step
    always_comb
    begin
        num_shift   = {num_reg, {FRAC_W{1'b0}}};
        ovf_next    = ({{(DSH_W+1-NUMS_W){1'b0}}, num_shift} >= {den_reg, {QUO_W{1'b0}}});
        div_rem_ext = DSH_W'(div_rem_reg);
        div_ge      = (div_rem_ext >= div_d_reg);
        quo_next    = {quo_reg[QUO_W-2:0], div_ge};
        div_neg     = (cmd.op == OP_DIV_Y) ? negy_reg : negx_reg;
        lim         = div_neg ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
        mag_sel     = (ovf_reg || quo_next > lim) ? lim : quo_next;
        accel_next  = div_neg ? 32'(-mag_sel) : 32'(mag_sel);
    end

    // divide by steps per unit through the reciprocal, truncating toward zero
    always_comb
    begin
        case (cmd.cnt[1:0])
            2'd0:    sc_val = own_vx_reg;
            2'd1:    sc_val = own_vy_reg;
            2'd2:    sc_val = ax_reg;
            default: sc_val = ay_reg;
        endcase
        sc_mag = sc_val[31] ? 32'(-sc_val) : 32'(sc_val);
        sc_q   = 32'(prod_reg >> RECIP_SHIFT);
        sc_res = pneg_reg ? 32'(-sc_q) : 32'(sc_q);
        sc_idx = 2'(cmd.cnt - 6'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg      <= GRAV_RESET;
            mass_reg   <= MASS_RESET;
            own_x_reg  <= '0;
            own_y_reg  <= '0;
            own_vx_reg <= '0;
            own_vy_reg <= '0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            own_x_reg  <= sat_add(own_x_reg, qvx_reg);
            own_y_reg  <= sat_add(own_y_reg, qvy_reg);
            own_vx_reg <= sat_add(own_vx_reg, qax_reg);
            own_vy_reg <= sat_add(own_vy_reg, qay_reg);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAV: g_reg      <= cfg_data;
                CFG_MASS: mass_reg   <= cfg_data;
                CFG_SX:   own_x_reg  <= cfg_data;
                CFG_SY:   own_y_reg  <= cfg_data;
                CFG_SVX:  own_vx_reg <= cfg_data;
                CFG_SVY:  own_vy_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                om_reg   <= other_mass;
                negx_reg <= dx_next[MAG_W-1];
                negy_reg <= dy_next[MAG_W-1];
                magx_reg <= dx_next[MAG_W-1] ? MAG_W'(-dx_next) : dx_next;
                magy_reg <= dy_next[MAG_W-1] ? MAG_W'(-dy_next) : dy_next;
                ax_reg   <= '0;
                ay_reg   <= '0;
            end
            OP_CHECK:
            begin
                fault_reg <= stat.mass_zero ? FAULT_MASS :
                             stat.s_zero    ? FAULT_COINCIDE : FAULT_NONE;
            end
            OP_SQRT:
            begin
                if (cmd.cnt == 6'd0)
                begin
                    sq_src_reg <= SRC_W'(s_reg);
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                end
                else
                begin
                    sq_src_reg <= {sq_src_reg[SRC_W-3:0], 2'b00};
                    sq_rem_reg <= sq_rem_next;
                    root_reg   <= root_next;
                end
            end
            OP_DIV_X, OP_DIV_Y:
            begin
                if (cmd.cnt == 6'd0)
                begin
                    ovf_reg     <= ovf_next;
                    div_rem_reg <= num_shift;
                    div_d_reg   <= {den_reg, {(QUO_W-1){1'b0}}};
                    quo_reg     <= '0;
                end
                else
                begin
                    div_rem_reg <= div_ge ? NUMS_W'(div_rem_ext - div_d_reg) : div_rem_reg;
                    div_d_reg   <= div_d_reg >> 1;
                    quo_reg     <= quo_next;
                    if (cmd.last)
                    begin
                        if (cmd.op == OP_DIV_X)
                        begin
                            ax_reg <= accel_next;
                        end
                        else
                        begin
                            ay_reg <= accel_next;
                        end
                    end
                end
            end
            OP_SCALE:
            begin
                if (cmd.cnt < SCALE_LAST)
                begin
                    prod_reg <= PROD_W'(sc_mag) * PROD_W'(RECIP);
                    pneg_reg <= sc_val[31];
                end
                if (cmd.cnt != 6'd0)
                begin
                    case (sc_idx)
                        2'd0:    qvx_reg <= sc_res;
                        2'd1:    qvy_reg <= sc_res;
                        2'd2:    qax_reg <= sc_res;
                        default: qay_reg <= sc_res;
                    endcase
                end
            end
            OP_FINISH:
            begin
                accel_x_reg   <= ax_reg;
                accel_y_reg   <= ay_reg;
                fault_out_reg <= fault_reg;
            end
            default: ;
        endcase

        if (is_mul)
        begin
            if (cmd.cnt == 6'd0)
            begin
                mul_a_reg <= mul_a_next;
                mul_b_reg <= mul_b_next;
                acc_reg   <= '0;
            end
            else
            begin
                mul_a_reg <= {mul_a_reg[MUL_W-2:0], 1'b0};
                mul_b_reg <= mul_b_reg >> 1;
                acc_reg   <= acc_next;
                if (cmd.last)
                begin
                    case (cmd.op)
                        OP_MUL_SX:  s_reg   <= SQ_W'(acc_next);
                        OP_MUL_SY:  s_reg   <= s_reg + SQ_W'(acc_next);
                        OP_MUL_GM:  gm_reg  <= GM_W'(acc_next);
                        OP_MUL_DEN: den_reg <= DEN_W'(acc_next);
                        default:    num_reg <= NUM_W'(acc_next);
                    endcase
                end
            end
        end
    end

    assign pos_x   = own_x_reg;
    assign pos_y   = own_y_reg;
    assign vel_x   = own_vx_reg;
    assign vel_y   = own_vy_reg;
    assign accel_x = accel_x_reg;
    assign accel_y = accel_y_reg;
    assign fault   = fault_out_reg;

endmodule

@@ sv/two_body_gravity_euler_step.sv @@
// top level of the two-body gravity euler step block
// One input beat advances the body by one step and yields one output beat. Every product
// goes through one serial shift-add multiplier at one bit per cycle (six of them in a full
// step; only the two squares when the bodies coincide or own mass is zero), the square
// root resolves one bit per cycle and each acceleration axis takes a restoring division.
// A new input beat is taken once the previous step has moved its result into the output
// registers; the output can sit stalled while the next step computes.
module two_body_gravity_euler_step
    import tbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   other_x,
    input  logic signed [31:0]   other_y,
    input  logic [31:0]          other_mass,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic signed [31:0]   accel_x,
    output logic signed [31:0]   accel_y,
    output logic [1:0]           fault
);

    cmd_t  cmd;
    stat_t stat;

    tbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tbg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .other_x    (other_x),
        .other_y    (other_y),
        .other_mass (other_mass),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .fault      (fault)
    );

    // an accepted beat keeps the input side stalled while the step runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fault == FAULT_NONE || fault == FAULT_COINCIDE || fault == FAULT_MASS))
        else $error("undefined fault code");

    // a flagged step carries no acceleration
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault != FAULT_NONE) |-> (accel_x == 32'sd0 && accel_y == 32'sd0))
        else $error("nonzero acceleration on a faulted step");

    // no new result can be produced while the input side is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared without a step in flight");

endmodule
